FILE: design/mbcs_pkg.sv
// Package for the motor and brake command sequencer.
// Holds the beat types, command codes, configuration record and speed clamp.
// No dependencies.
package mbcs_pkg;

    // Command codes of the input beat.
    localparam logic [3:0] CMD_TICK       = 4'd0;
    localparam logic [3:0] CMD_FORWARD    = 4'd1;
    localparam logic [3:0] CMD_REVERSE    = 4'd2;
    localparam logic [3:0] CMD_MOVE       = 4'd3;
    localparam logic [3:0] CMD_SPIN_LEFT  = 4'd4;
    localparam logic [3:0] CMD_SPIN_RIGHT = 4'd5;
    localparam logic [3:0] CMD_PAIR       = 4'd6;
    localparam logic [3:0] CMD_BRAKE      = 4'd7;
    localparam logic [3:0] CMD_STOP       = 4'd8;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_SPEED   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INVERT_LEFT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_DELAY   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ENGAGE_DELAY    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COMMAND_TIMEOUT = 3'd5;

    // Reset values of the configuration registers.
    localparam logic [7:0]  RST_DEFAULT_SPEED   = 8'd160;
    localparam logic [7:0]  RST_SPEED_LIMIT     = 8'd255;
    localparam logic        RST_INVERT_LEFT     = 1'b1;
    localparam logic [15:0] RST_RELEASE_DELAY   = 16'd250;
    localparam logic [15:0] RST_ENGAGE_DELAY    = 16'd120;
    localparam logic [15:0] RST_COMMAND_TIMEOUT = 16'd250;

    // The idle tick counter saturates at its all-ones value.
    localparam logic [16:0] IDLE_MAX = 17'h1FFFF;

    typedef struct packed {
        logic [3:0]         command;
        logic signed [15:0] speed_arg;
        logic signed [15:0] second_arg;
        logic               pair_ok;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] left_fwd_duty;
        logic [7:0] left_rev_duty;
        logic [7:0] right_fwd_duty;
        logic [7:0] right_rev_duty;
        logic       left_enable;
        logic       right_enable;
        logic       brake_released;
        logic       waiting;
        logic       rejected;
        logic       timeout_fired;
    } t_out_beat;

    typedef struct packed {
        logic [7:0]  default_speed;
        logic [7:0]  speed_limit;
        logic        invert_left;
        logic [15:0] release_delay;
        logic [15:0] engage_delay;
        logic [15:0] command_timeout;
    } t_cfg;

    // Limits a signed speed to plus or minus lim.
    function automatic logic signed [8:0] clamp_speed(input logic signed [16:0] v,
                                                      input logic [7:0] lim);
        logic signed [16:0] m;
        logic signed [16:0] nm;
        logic signed [16:0] r;
        begin
            m  = signed'({9'd0, lim});
            nm = -m;
            if (v > m) begin
                r = m;
            end else if (v < nm) begin
                r = nm;
            end else begin
                r = v;
            end
            return signed'(r[8:0]);
        end
    endfunction

endpackage

FILE: design/mbcs_cfg_regs.sv
// Configuration register file of the motor and brake command sequencer.
// Depends on mbcs_pkg for the register indexes, reset values and record type.
module mbcs_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_wr,
    input  logic [mbcs_pkg::CFG_IDX_W-1:0]    i_index,
    input  logic [mbcs_pkg::CFG_DATA_W-1:0]   i_data,
    output mbcs_pkg::t_cfg                    o_cfg
);

    mbcs_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.default_speed   <= mbcs_pkg::RST_DEFAULT_SPEED;
            r_cfg.speed_limit     <= mbcs_pkg::RST_SPEED_LIMIT;
            r_cfg.invert_left     <= mbcs_pkg::RST_INVERT_LEFT;
            r_cfg.release_delay   <= mbcs_pkg::RST_RELEASE_DELAY;
            r_cfg.engage_delay    <= mbcs_pkg::RST_ENGAGE_DELAY;
            r_cfg.command_timeout <= mbcs_pkg::RST_COMMAND_TIMEOUT;
        end else if (i_wr) begin
            unique case (i_index)
                mbcs_pkg::REG_DEFAULT_SPEED:   r_cfg.default_speed   <= i_data[7:0];
                mbcs_pkg::REG_SPEED_LIMIT:     r_cfg.speed_limit     <= i_data[7:0];
                mbcs_pkg::REG_INVERT_LEFT:     r_cfg.invert_left     <= i_data[0];
                mbcs_pkg::REG_RELEASE_DELAY:   r_cfg.release_delay   <= i_data;
                mbcs_pkg::REG_ENGAGE_DELAY:    r_cfg.engage_delay    <= i_data;
                mbcs_pkg::REG_COMMAND_TIMEOUT: r_cfg.command_timeout <= i_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: design/mbcs_core.sv
// Sequencer state and its combinational update for one command or tick beat.
// Depends on mbcs_pkg for beat types, command codes and the speed clamp.
module mbcs_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fire,
    input  mbcs_pkg::t_in_beat   i_item,
    input  mbcs_pkg::t_cfg       i_cfg,
    output mbcs_pkg::t_out_beat  o_result
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_RELEASE,
        PH_ENGAGE
    } t_phase;

    t_phase             r_phase, n_phase;
    logic               r_brake_open, n_brake_open;
    logic signed [8:0]  r_left, n_left;
    logic signed [8:0]  r_right, n_right;
    logic               r_len, n_len;
    logic               r_ren, n_ren;
    logic [15:0]        r_wait, n_wait;
    logic signed [8:0]  r_pend_left, n_pend_left;
    logic signed [8:0]  r_pend_right, n_pend_right;
    logic [16:0]        r_idle, n_idle;

    logic               rejected;
    logic               fired;
    logic               do_drive;
    logic               do_stop;
    logic               do_release;
    logic signed [16:0] arg_a;
    logic signed [16:0] arg_b;
    logic signed [16:0] v_pos;
    logic signed [16:0] v_neg;
    logic signed [16:0] drv_l;
    logic signed [16:0] drv_r;
    logic signed [8:0]  cl_a;
    logic signed [8:0]  cl_b;
    logic signed [8:0]  cl_l;
    logic signed [8:0]  cl_r;
    logic [15:0]        cnt;
    logic [16:0]        idle_inc;
    logic               was_running;
    logic signed [8:0]  neg_left;
    logic signed [8:0]  neg_right;

    assign arg_a = {i_item.speed_arg[15], i_item.speed_arg};
    assign arg_b = {i_item.second_arg[15], i_item.second_arg};
    // A speed argument that is zero or negative falls back to the default.
    assign v_pos = (i_item.speed_arg[15] || (i_item.speed_arg == 16'sd0))
                   ? signed'({9'd0, i_cfg.default_speed}) : arg_a;
    assign v_neg = -v_pos;
    assign cl_a  = mbcs_pkg::clamp_speed(arg_a, i_cfg.speed_limit);
    assign cl_b  = mbcs_pkg::clamp_speed(arg_b, i_cfg.speed_limit);

    always_comb begin
        n_phase      = r_phase;
        n_brake_open = r_brake_open;
        n_left       = r_left;
        n_right      = r_right;
        n_len        = r_len;
        n_ren        = r_ren;
        n_wait       = r_wait;
        n_pend_left  = r_pend_left;
        n_pend_right = r_pend_right;
        n_idle       = r_idle;
        rejected     = 1'b0;
        fired        = 1'b0;
        do_drive     = 1'b0;
        do_stop      = 1'b0;
        do_release   = 1'b0;
        drv_l        = '0;
        drv_r        = '0;
        cnt          = r_wait;
        idle_inc     = r_idle;
        cl_l         = '0;
        cl_r         = '0;
        was_running  = (r_left != 9'sd0) || (r_right != 9'sd0);

        if (i_item.command == mbcs_pkg::CMD_TICK) begin
            if (r_phase != PH_IDLE) begin
                if (r_wait != 16'd0) begin
                    cnt = r_wait - 16'd1;
                end
                n_wait = cnt;
                if (cnt == 16'd0) begin
                    if (r_phase == PH_RELEASE) begin
                        n_left  = r_pend_left;
                        n_right = r_pend_right;
                        if (r_pend_left != 9'sd0) begin
                            n_len = 1'b1;
                        end
                        if (r_pend_right != 9'sd0) begin
                            n_ren = 1'b1;
                        end
                    end else begin
                        n_brake_open = 1'b0;
                    end
                    n_phase = PH_IDLE;
                    n_idle  = '0;
                end
            end else begin
                if (r_idle != mbcs_pkg::IDLE_MAX) begin
                    idle_inc = r_idle + 17'd1;
                end
                n_idle = idle_inc;
                if (idle_inc > {1'b0, i_cfg.command_timeout}) begin
                    do_stop = 1'b1;
                    fired   = 1'b1;
                    n_idle  = '0;
                end
            end
        end else if (r_phase != PH_IDLE) begin
            rejected = 1'b1;
        end else begin
            n_idle = '0;
            unique case (i_item.command)
                mbcs_pkg::CMD_FORWARD: begin
                    do_drive = 1'b1;
                    drv_l    = v_pos;
                    drv_r    = v_pos;
                end
                mbcs_pkg::CMD_REVERSE: begin
                    do_drive = 1'b1;
                    drv_l    = v_neg;
                    drv_r    = v_neg;
                end
                mbcs_pkg::CMD_MOVE: begin
                    if (cl_a == 9'sd0) begin
                        do_stop = 1'b1;
                    end else begin
                        do_drive = 1'b1;
                        drv_l    = arg_a;
                        drv_r    = arg_a;
                    end
                end
                mbcs_pkg::CMD_SPIN_LEFT: begin
                    do_drive = 1'b1;
                    drv_l    = v_neg;
                    drv_r    = v_pos;
                end
                mbcs_pkg::CMD_SPIN_RIGHT: begin
                    do_drive = 1'b1;
                    drv_l    = v_pos;
                    drv_r    = v_neg;
                end
                mbcs_pkg::CMD_PAIR: begin
                    if (!i_item.pair_ok || ((cl_a == 9'sd0) && (cl_b == 9'sd0))) begin
                        do_stop = 1'b1;
                    end else begin
                        do_drive = 1'b1;
                        drv_l    = arg_a;
                        drv_r    = arg_b;
                    end
                end
                mbcs_pkg::CMD_BRAKE: begin
                    if (i_item.speed_arg != 16'sd0) begin
                        do_release = 1'b1;
                    end else begin
                        do_stop = 1'b1;
                    end
                end
                default: begin
                    do_stop = 1'b1;
                end
            endcase
        end

        if (do_drive) begin
            cl_l = mbcs_pkg::clamp_speed(drv_l, i_cfg.speed_limit);
            cl_r = mbcs_pkg::clamp_speed(drv_r, i_cfg.speed_limit);
            if (i_cfg.invert_left) begin
                cl_l = -cl_l;
            end
            n_brake_open = 1'b1;
            if (r_brake_open || (i_cfg.release_delay == 16'd0)) begin
                n_left  = cl_l;
                n_right = cl_r;
                if (cl_l != 9'sd0) begin
                    n_len = 1'b1;
                end
                if (cl_r != 9'sd0) begin
                    n_ren = 1'b1;
                end
            end else begin
                n_pend_left  = cl_l;
                n_pend_right = cl_r;
                n_phase      = PH_RELEASE;
                n_wait       = i_cfg.release_delay;
            end
        end

        if (do_stop) begin
            n_left  = '0;
            n_right = '0;
            if (r_brake_open) begin
                if (was_running && (i_cfg.engage_delay != 16'd0)) begin
                    n_phase = PH_ENGAGE;
                    n_wait  = i_cfg.engage_delay;
                end else begin
                    n_brake_open = 1'b0;
                end
            end
        end

        if (do_release && !r_brake_open) begin
            n_brake_open = 1'b1;
            if (i_cfg.release_delay != 16'd0) begin
                n_pend_left  = r_left;
                n_pend_right = r_right;
                n_phase      = PH_RELEASE;
                n_wait       = i_cfg.release_delay;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_brake_open <= 1'b0;
            r_left       <= '0;
            r_right      <= '0;
            r_len        <= 1'b0;
            r_ren        <= 1'b0;
            r_wait       <= '0;
            r_pend_left  <= '0;
            r_pend_right <= '0;
            r_idle       <= '0;
        end else if (i_fire) begin
            r_phase      <= n_phase;
            r_brake_open <= n_brake_open;
            r_left       <= n_left;
            r_right      <= n_right;
            r_len        <= n_len;
            r_ren        <= n_ren;
            r_wait       <= n_wait;
            r_pend_left  <= n_pend_left;
            r_pend_right <= n_pend_right;
            r_idle       <= n_idle;
        end
    end

    // Duties show the magnitude on the side of the sign.
    assign neg_left  = -n_left;
    assign neg_right = -n_right;

    always_comb begin
        o_result                = '0;
        o_result.left_fwd_duty  = (n_left > 9'sd0) ? n_left[7:0] : 8'd0;
        o_result.left_rev_duty  = (n_left < 9'sd0) ? neg_left[7:0] : 8'd0;
        o_result.right_fwd_duty = (n_right > 9'sd0) ? n_right[7:0] : 8'd0;
        o_result.right_rev_duty = (n_right < 9'sd0) ? neg_right[7:0] : 8'd0;
        o_result.left_enable    = n_len;
        o_result.right_enable   = n_ren;
        o_result.brake_released = n_brake_open;
        o_result.waiting        = (n_phase != PH_IDLE);
        o_result.rejected       = rejected;
        o_result.timeout_fired  = fired;
    end

endmodule

FILE: design/motor_brake_command_sequencer.sv
// Motor and brake command sequencer: an accepted input beat passes through the input
// register, then the state update into the result register, to become the result beat.
// Throughput is one beat per cycle while not stalled; the whole state update for a beat
// is combinational logic in mbcs_core, so the next beat sees the new state at once.
// Reset is synchronous and active low: the brake engages, speeds, latches and counters
// clear, and the configuration registers return to their default values.
module motor_brake_command_sequencer (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  mbcs_pkg::t_in_beat                i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output mbcs_pkg::t_out_beat               o_out_data,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [mbcs_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [mbcs_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    // Input register stage. It holds one beat until the result register can
    // take its result; the result register then holds that result while the
    // next beat is already taken in, so the two sides are decoupled.
    logic                 r_s1_valid;
    mbcs_pkg::t_in_beat   r_s1_data;
    logic                 r_out_valid;
    mbcs_pkg::t_out_beat  r_out_data;

    logic                 advance;
    logic                 fire;
    logic                 in_accept;
    mbcs_pkg::t_cfg       cfg;
    mbcs_pkg::t_out_beat  result;

    // The result register can be loaded when it is empty or is being drained.
    assign advance    = !r_out_valid || !i_out_stall;
    // The beat in the input register updates the state when it moves on.
    assign fire       = r_s1_valid && advance;
    assign o_in_stall = r_s1_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    // Configuration writes are always taken; the user must issue them only while idle.
    assign o_cfg_ready = 1'b1;

    mbcs_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    mbcs_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_s1_data),
        .i_cfg    (cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (fire) begin
                r_s1_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= fire;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_data <= i_in_data;
        end
        if (fire) begin
            r_out_data <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

`ifndef SYNTHESIS
    // A beat cannot be both dropped during a wait and a timeout tick.
    a_rej_fire_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.rejected && o_out_data.timeout_fired))
        else $error("rejected and timeout_fired set in the same result");

    // Both kinds of wait run with the brake released.
    a_wait_brake: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.waiting) |-> o_out_data.brake_released)
        else $error("wait reported with brake engaged");

    // A bridge never gets forward and reverse duty at once.
    a_duty_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (((o_out_data.left_fwd_duty == 8'd0) ||
                          (o_out_data.left_rev_duty == 8'd0)) &&
                         ((o_out_data.right_fwd_duty == 8'd0) ||
                          (o_out_data.right_rev_duty == 8'd0))))
        else $error("forward and reverse duty both nonzero");

    // A beat held by a stalled result register stays in the input register.
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && o_in_stall) |=> r_s1_valid)
        else $error("input register lost a stalled beat");
`endif

endmodule
